// ===== rtl/cmgp_pkg.sv =====
// ----------------------------------------------------------------------------
// cmgp_pkg
// Shared widths and the stored point record for the grasp point block.
// ----------------------------------------------------------------------------
package cmgp_pkg;

  localparam int COORD_W   = 16;
  localparam int OUT_IDX_W = 10;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

endpackage

// ===== rtl/cmgp_store.sv =====
// ----------------------------------------------------------------------------
// cmgp_store
// Point memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cmgp_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  cmgp_pkg::point_t wdata,
  input  logic [AW-1:0]   raddr,
  output cmgp_pkg::point_t rdata
);

  cmgp_pkg::point_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/centroid_mirror_grasp_points.sv =====
// ----------------------------------------------------------------------------
// centroid_mirror_grasp_points
// Loads one outline, then finds centroid, nearest point, its mirror partner
// and their midpoint.
// Points load at one per cycle. After the last point: serial division per axis,
// a set-up state then one quotient bit a cycle, then two search passes that
// step each stored point through a read, an x-square and a y-square state on one
// shared multiplier, then the result waits in its register until taken.
// No point is taken meanwhile.
// Synchronous active-low reset empties the outline; memory is not cleared.
// ----------------------------------------------------------------------------
module centroid_mirror_grasp_points #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [cmgp_pkg::COORD_W-1:0]  in_px,
  input  logic signed [cmgp_pkg::COORD_W-1:0]  in_py,
  input  logic signed [cmgp_pkg::COORD_W-1:0]  in_pz,
  input  logic                                 in_final_point,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [cmgp_pkg::OUT_IDX_W-1:0]       out_near_index,
  output logic [cmgp_pkg::OUT_IDX_W-1:0]       out_opposite_index,
  output logic signed [cmgp_pkg::COORD_W-1:0]  out_mid_x,
  output logic signed [cmgp_pkg::COORD_W-1:0]  out_mid_y,
  output logic signed [cmgp_pkg::COORD_W-1:0]  out_mid_z,
  output logic signed [cmgp_pkg::COORD_W-1:0]  out_cen_x,
  output logic signed [cmgp_pkg::COORD_W-1:0]  out_cen_y,
  output logic signed [cmgp_pkg::COORD_W-1:0]  out_cen_z,
  output logic                                 out_overflowed
);

  localparam int CRW   = cmgp_pkg::COORD_W;
  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int AW    = $clog2(MAX_POINTS);
  localparam int SW    = CRW + CW;
  localparam int DCW   = $clog2(SW + 1);
  localparam int TW    = CRW + 2;
  localparam int DW    = TW + 1;
  localparam int DSQ_W = 2 * DW - 1;

  typedef enum logic [6:0] {
    ST_LOAD = 7'b0000001,
    ST_DSET = 7'b0000010,
    ST_DIV  = 7'b0000100,
    ST_SRD  = 7'b0001000,
    ST_SQX  = 7'b0010000,
    ST_SQY  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  state_t state_r;
  logic [CW-1:0]           count_r;
  logic signed [SW-1:0]    sum_x_r, sum_y_r, sum_z_r;
  logic                    drop_r;
  logic [1:0]              axis_r;
  logic [DCW-1:0]          dcnt_r;
  logic [SW-1:0]           quo_r;
  logic [CW-1:0]           rem_r;
  logic                    neg_r;
  logic signed [CRW-1:0]   cen_x_r, cen_y_r, cen_z_r;
  logic                    pass_r;
  logic [CW-1:0]           idx_r;
  logic [DSQ_W:0]          best_r;
  logic [AW-1:0]           best_idx_r;
  cmgp_pkg::point_t        best_pt_r;
  cmgp_pkg::point_t        a_pt_r;
  logic [AW-1:0]           a_idx_r, b_idx_r;
  logic signed [TW-1:0]    tx_r, ty_r;
  logic [DSQ_W-1:0]        dist_r;
  logic signed [CRW-1:0]   mid_x_r, mid_y_r, mid_z_r;
  logic                    ovf_r;

  cmgp_pkg::point_t wr_pt, rd_pt;
  logic                    store_ok, in_xfer, out_xfer;

  assign in_ready  = (state_r == ST_LOAD);
  assign out_valid = (state_r == ST_OUT);
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;
  assign store_ok  = (count_r < CW'(MAX_POINTS));
  assign wr_pt     = '{x: in_px, y: in_py, z: in_pz};

  cmgp_store #(.DEPTH(MAX_POINTS), .AW(AW)) u_store (
    .clk   (clk),
    .we    (in_xfer && store_ok),
    .waddr (count_r[AW-1:0]),
    .wdata (wr_pt),
    .raddr (idx_r[AW-1:0]),
    .rdata (rd_pt)
  );

  // serial divider step
  logic [CW:0]           rem_t, rem_s;
  logic                  ge;
  logic [SW-1:0]         quo_sh;
  logic [CRW-1:0]        qmag, qres;
  logic signed [SW-1:0]  sum_sel;

  always_comb begin
    rem_t  = {rem_r, quo_r[SW-1]};
    ge     = (rem_t >= {1'b0, count_r});
    rem_s  = ge ? (rem_t - {1'b0, count_r}) : rem_t;
    quo_sh = {quo_r[SW-2:0], ge};
    qmag   = quo_sh[CRW-1:0];
    qres   = neg_r ? (CRW'(0) - qmag) : qmag;
    case (axis_r)
      2'd0:    sum_sel = sum_x_r;
      2'd1:    sum_sel = sum_y_r;
      default: sum_sel = sum_z_r;
    endcase
  end

  // shared squarer
  logic signed [DW-1:0]    dx, dy, mop;
  logic signed [2*DW-1:0]  prod;
  logic [DSQ_W:0]          dsum;
  logic                    take, last_pt;
  logic [AW-1:0]           sel_idx;
  cmgp_pkg::point_t        sel_pt;
  logic signed [CRW:0]     msum_x, msum_y, msum_z;

  always_comb begin
    dx      = DW'(tx_r) - DW'(rd_pt.x);
    dy      = DW'(ty_r) - DW'(rd_pt.y);
    mop     = (state_r == ST_SQY) ? dy : dx;
    prod    = mop * mop;
    dsum    = {1'b0, dist_r} + {1'b0, prod[DSQ_W-1:0]};
    take    = (idx_r == '0) || (dsum < best_r);
    sel_idx = take ? idx_r[AW-1:0] : best_idx_r;
    sel_pt  = take ? rd_pt : best_pt_r;
    last_pt = ((idx_r + CW'(1)) == count_r);
    msum_x  = (CRW+1)'(a_pt_r.x) + (CRW+1)'(sel_pt.x);
    msum_y  = (CRW+1)'(a_pt_r.y) + (CRW+1)'(sel_pt.y);
    msum_z  = (CRW+1)'(a_pt_r.z) + (CRW+1)'(sel_pt.z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      sum_x_r <= '0;
      sum_y_r <= '0;
      sum_z_r <= '0;
      drop_r  <= 1'b0;
      axis_r  <= '0;
      dcnt_r  <= '0;
      pass_r  <= 1'b0;
      idx_r   <= '0;
    end else begin
      unique case (state_r)
        ST_LOAD: begin
          if (in_xfer) begin
            if (store_ok) begin
              count_r <= count_r + CW'(1);
              sum_x_r <= sum_x_r + SW'(in_px);
              sum_y_r <= sum_y_r + SW'(in_py);
              sum_z_r <= sum_z_r + SW'(in_pz);
            end else begin
              drop_r <= 1'b1;
            end
            if (in_final_point) begin
              axis_r  <= '0;
              state_r <= ST_DSET;
            end
          end
        end
        ST_DSET: begin
          neg_r   <= sum_sel[SW-1];
          quo_r   <= sum_sel[SW-1] ? (SW'(0) - sum_sel) : sum_sel;
          rem_r   <= '0;
          dcnt_r  <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          quo_r  <= quo_sh;
          rem_r  <= rem_s[CW-1:0];
          dcnt_r <= dcnt_r + DCW'(1);
          if (dcnt_r == DCW'(SW - 1)) begin
            case (axis_r)
              2'd0:    cen_x_r <= qres;
              2'd1:    cen_y_r <= qres;
              default: cen_z_r <= qres;
            endcase
            if (axis_r == 2'd2) begin
              tx_r    <= TW'(cen_x_r);
              ty_r    <= TW'(cen_y_r);
              pass_r  <= 1'b0;
              idx_r   <= '0;
              state_r <= ST_SRD;
            end else begin
              axis_r  <= axis_r + 2'd1;
              state_r <= ST_DSET;
            end
          end
        end
        ST_SRD: state_r <= ST_SQX;
        ST_SQX: begin
          dist_r  <= prod[DSQ_W-1:0];
          state_r <= ST_SQY;
        end
        ST_SQY: begin
          if (take) begin
            best_r     <= dsum;
            best_idx_r <= idx_r[AW-1:0];
            best_pt_r  <= rd_pt;
          end
          if (last_pt) begin
            idx_r <= '0;
            if (!pass_r) begin
              a_idx_r <= sel_idx;
              a_pt_r  <= sel_pt;
              tx_r    <= {cen_x_r[CRW-1], cen_x_r, 1'b0} - TW'(sel_pt.x);
              ty_r    <= {cen_y_r[CRW-1], cen_y_r, 1'b0} - TW'(sel_pt.y);
              pass_r  <= 1'b1;
              state_r <= ST_SRD;
            end else begin
              b_idx_r <= sel_idx;
              mid_x_r <= msum_x[CRW:1];
              mid_y_r <= msum_y[CRW:1];
              mid_z_r <= msum_z[CRW:1];
              ovf_r   <= drop_r;
              state_r <= ST_OUT;
            end
          end else begin
            idx_r   <= idx_r + CW'(1);
            state_r <= ST_SRD;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            count_r <= '0;
            sum_x_r <= '0;
            sum_y_r <= '0;
            sum_z_r <= '0;
            drop_r  <= 1'b0;
            state_r <= ST_LOAD;
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  assign out_near_index     = cmgp_pkg::OUT_IDX_W'(a_idx_r);
  assign out_opposite_index = cmgp_pkg::OUT_IDX_W'(b_idx_r);
  assign out_mid_x          = mid_x_r;
  assign out_mid_y          = mid_y_r;
  assign out_mid_z          = mid_z_r;
  assign out_cen_x          = cen_x_r;
  assign out_cen_y          = cen_y_r;
  assign out_cen_z          = cen_z_r;
  assign out_overflowed     = ovf_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_POINTS)) else $error("point count beyond capacity");

  a_search_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQY) |-> (idx_r < count_r)) else $error("search index past count");

  a_clear_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |=> (count_r == '0 && !drop_r)) else $error("outline not cleared");
`endif

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for centroid_mirror_grasp_points. Streams hull outlines
// of random and hand-picked points through the valid/ready ports, predicts
// centroid, nearest and mirror indices and midpoint per outline, and checks
// every result transfer under random idling and stalls on both sides.
// ----------------------------------------------------------------------------
module tb;

  localparam int COORD_W   = cmgp_pkg::COORD_W;
  localparam int OUT_IDX_W = cmgp_pkg::OUT_IDX_W;
  localparam int CAPACITY  = 1024;

  typedef struct {
    logic [OUT_IDX_W-1:0]      near_idx;
    logic [OUT_IDX_W-1:0]      opp_idx;
    logic signed [COORD_W-1:0] mx, my, mz;
    logic signed [COORD_W-1:0] cx, cy, cz;
    logic                      ovf;
  } grasp_t;

  class grasp_scoreboard;
    longint px_mem[CAPACITY];
    longint py_mem[CAPACITY];
    longint pz_mem[CAPACITY];
    int     n_pts;
    longint sx, sy, sz;
    bit     dropped;
    grasp_t pending[$];
    int     errors;
    int     n_checked;
    int     n_overflow;

    function int closest(longint tx, longint ty);
      int i;
      int best;
      longint dx, dy, d, best_d;
      best = 0;
      best_d = -1;
      for (i = 0; i < n_pts; i++) begin
        dx = tx - px_mem[i];
        dy = ty - py_mem[i];
        d = dx * dx + dy * dy;
        if (best_d < 0 || d < best_d) begin
          best_d = d;
          best = i;
        end
      end
      return best;
    endfunction

    function void note_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                             logic signed [COORD_W-1:0] z, logic fin);
      grasp_t g;
      longint cx, cy, cz;
      int a, b;
      if (n_pts < CAPACITY) begin
        px_mem[n_pts] = x;
        py_mem[n_pts] = y;
        pz_mem[n_pts] = z;
        sx += x;
        sy += y;
        sz += z;
        n_pts++;
      end else begin
        dropped = 1;
      end
      if (!fin) return;
      cx = sx / longint'(n_pts);
      cy = sy / longint'(n_pts);
      cz = sz / longint'(n_pts);
      a = closest(cx, cy);
      b = closest(2 * cx - px_mem[a], 2 * cy - py_mem[a]);
      g.near_idx = a[OUT_IDX_W-1:0];
      g.opp_idx  = b[OUT_IDX_W-1:0];
      g.mx = COORD_W'((px_mem[a] + px_mem[b]) >>> 1);
      g.my = COORD_W'((py_mem[a] + py_mem[b]) >>> 1);
      g.mz = COORD_W'((pz_mem[a] + pz_mem[b]) >>> 1);
      g.cx = cx[COORD_W-1:0];
      g.cy = cy[COORD_W-1:0];
      g.cz = cz[COORD_W-1:0];
      g.ovf = dropped;
      if (dropped) n_overflow++;
      pending = {pending, g};
      n_pts = 0;
      sx = 0;
      sy = 0;
      sz = 0;
      dropped = 0;
    endfunction

    function void cmp(string name, longint e, longint a);
      if (e != a) begin
        errors++;
        $display("%0t mismatch %s: expected %0d actual %0d", $time, name, e, a);
      end
    endfunction

    function void check_result(grasp_t r);
      grasp_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual near=%0d", $time, r.near_idx);
        return;
      end
      e = pending.pop_front();
      n_checked++;
      cmp("near_index", e.near_idx, r.near_idx);
      cmp("opposite_index", e.opp_idx, r.opp_idx);
      cmp("mid_x", e.mx, r.mx);
      cmp("mid_y", e.my, r.my);
      cmp("mid_z", e.mz, r.mz);
      cmp("cen_x", e.cx, r.cx);
      cmp("cen_y", e.cy, r.cy);
      cmp("cen_z", e.cz, r.cz);
      cmp("overflowed", e.ovf, r.ovf);
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [COORD_W-1:0] in_px = '0, in_py = '0, in_pz = '0;
  logic in_final_point = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [OUT_IDX_W-1:0] out_near_index, out_opposite_index;
  logic signed [COORD_W-1:0] out_mid_x, out_mid_y, out_mid_z;
  logic signed [COORD_W-1:0] out_cen_x, out_cen_y, out_cen_z;
  logic out_overflowed;

  grasp_scoreboard sb = new();
  bit   hold_rx = 0;
  bit   rx_ready_en = 0;
  bit   no_gaps = 0;
  int   n_sent = 0;

  centroid_mirror_grasp_points #(.MAX_POINTS(CAPACITY)) dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_px, .in_py, .in_pz, .in_final_point,
    .out_valid, .out_ready, .out_near_index, .out_opposite_index,
    .out_mid_x, .out_mid_y, .out_mid_z, .out_cen_x, .out_cen_y, .out_cen_z,
    .out_overflowed
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 3000000);
    $display("[FAIL] regression broken");
    $finish;
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function logic signed [COORD_W-1:0] pick_coord(int mode);
    case (mode)
      0: return COORD_W'($urandom);
      1: return COORD_W'($urandom_range(0, 40) - 20);
      default: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  task send_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                  logic signed [COORD_W-1:0] z, logic fin);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_px <= x;
    in_py <= y;
    in_pz <= z;
    in_final_point <= fin;
    do @(posedge clk); while (!in_ready);
    sb.note_point(x, y, z, fin);
    n_sent++;
  endtask

  task send_outline(int len, int mode);
    int i;
    for (i = 0; i < len; i++)
      send_point(pick_coord(mode), pick_coord(mode), pick_coord(mode), i == len - 1);
  endtask

  task wait_drained();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  initial begin
    grasp_t r;
    forever begin
      if (hold_rx) begin
        out_ready <= 0;
        repeat (400) @(posedge clk);
        hold_rx = 0;
      end
      out_ready <= rx_ready_en && ($urandom_range(0, 9) < 7 || $urandom_range(0, 1));
      @(posedge clk);
      if (out_valid && out_ready) begin
        r.near_idx = out_near_index;
        r.opp_idx = out_opposite_index;
        r.mx = out_mid_x;
        r.my = out_mid_y;
        r.mz = out_mid_z;
        r.cx = out_cen_x;
        r.cy = out_cen_y;
        r.cz = out_cen_z;
        r.ovf = out_overflowed;
        sb.check_result(r);
      end
    end
  end

  initial begin
    int i, len, wait_cnt;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    rx_ready_en = 1;

    // directed: extremes, ties, truncation of negative means
    send_point(16'sh7fff, 16'sh7fff, 16'sh7fff, 1);
    send_point(16'sh8000, 16'sh8000, 16'sh8000, 1);
    send_point(-16'sd1, 16'sd0, -16'sd3, 0);
    send_point(-16'sd2, 16'sd0, 16'sd2, 1);
    send_point(16'sd10, 16'sd0, 16'sd0, 0);
    send_point(-16'sd10, 16'sd0, 16'sd0, 0);
    send_point(16'sd0, 16'sd10, 16'sd5, 0);
    send_point(16'sd0, -16'sd10, -16'sd5, 1);
    send_point(16'sh7fff, 16'sh8000, 16'sh7fff, 0);
    send_point(16'sh8000, 16'sh7fff, 16'sh8000, 0);
    send_point(16'sh7fff, 16'sh7fff, 16'sh8000, 0);
    send_point(16'sh8000, 16'sh8000, 16'sh7fff, 1);
    send_point(16'sd5, 16'sd5, 16'sd1, 0);
    send_point(16'sd5, 16'sd5, 16'sd2, 0);
    send_point(16'sd5, 16'sd5, 16'sd3, 1);
    send_point(16'sh7fff, 16'sh0000, 16'sh5555, 0);
    send_point(16'sh8000, 16'shffff, 16'shaaaa, 1);
    wait_drained();

    // receiver holds off while the sender keeps offering
    hold_rx = 1;
    for (i = 0; i < 6; i++) send_outline($urandom_range(1, 4), 1);
    wait_drained();

    // full store: the last two points, the final one among them, are dropped
    no_gaps = 1;
    for (i = 0; i < CAPACITY + 2; i++)
      send_point(pick_coord(i % 3), pick_coord(0), pick_coord(0), i == CAPACITY + 1);
    no_gaps = 0;
    wait_drained();

    while (n_sent < 1500) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      send_outline(len, $urandom_range(0, 9) < 5 ? 0 : ($urandom_range(0, 3) == 0 ? 2 : 1));
      if ($urandom_range(0, 29) == 0) wait_drained();
    end

    in_valid <= 0;
    wait_cnt = 0;
    while (sb.pending.size() != 0 && wait_cnt < 200000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (50) @(posedge clk);
    if (sb.pending.size() != 0) begin
      sb.errors++;
      $display("%0t %0d expected results never arrived", $time, sb.pending.size());
    end
    $display("Sent %0d points, checked %0d outline results (%0d with dropped points).",
             n_sent, sb.n_checked, sb.n_overflow);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
